>>> src/newton_fractal_pixel_top_defines.svh
// ---------------------------------------------------------------------------
// Newton fractal pixel: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef NEWTON_FRACTAL_PIXEL_TOP_DEFINES_SVH
`define NEWTON_FRACTAL_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication.
`define NFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nfp_pkg.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel package
// Types, constants, command/status structs and the datapath microprogram.
// ---------------------------------------------------------------------------
package nfp_pkg;

  localparam int IMAGE_WIDTH  = 800;
  localparam int IMAGE_HEIGHT = 600;

  localparam int PIX_W     = 10;
  localparam int Q_W       = 32;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CAP = 2'd2;

  localparam logic [Q_W-1:0]   C_REAL_RST   = 32'h1000_0000;
  localparam logic [Q_W-1:0]   C_IMAG_RST   = 32'h0000_0000;
  localparam logic [CNT_W-1:0] STEP_CAP_RST = 8'd50;

  // floor(1e-8 * 2^56)
  localparam logic [63:0] CONV_LIMIT = 64'd720575940;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [3:0] SHADE_K_RED   = 4'd5;
  localparam logic [3:0] SHADE_K_GREEN = 4'd7;
  localparam logic [3:0] SHADE_K_BLUE  = 4'd11;

  typedef enum logic [2:0] {
    OP_ZR, OP_ZI, OP_AR, OP_AI, OP_FR, OP_FI, OP_DR, OP_DI
  } opnd_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_AR, WB_AI, WB_FR, WB_FI, WB_MAG, WB_D, WB_DEN, WB_NUM, WB_Z
  } wb_t;

  typedef struct packed {
    opnd_t   a_sel;
    opnd_t   b_sel;
    acc_op_t acc;
    wb_t     wb;
    logic    last;
  } uop_t;

  typedef enum logic [1:0] {DIV_MAPX, DIV_MAPY, DIV_QR, DIV_QI} div_mode_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} div_state_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MAPX, ST_MAPX_W, ST_MAPY, ST_MAPY_W, ST_CUBE, ST_LIMIT,
    ST_DEN, ST_DZ, ST_NR, ST_DIVR, ST_DIVR_W, ST_NI, ST_DIVI, ST_DIVI_W,
    ST_ZUPD, ST_CUBE2, ST_CONV, ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    uop_t      uop;
    logic      in_load;
    logic      div_start;
    div_mode_t div_mode;
    logic      n_inc;
    logic      n_max;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic conv;
    logic den_zero;
    logic n_lim;
    logic out_free;
  } dp_stat_t;

  // Microprogram segment entry points
  localparam logic [PC_W-1:0] SEG_CM  = 5'd0;
  localparam logic [PC_W-1:0] SEG_DEN = 5'd14;
  localparam logic [PC_W-1:0] SEG_NR  = 5'd19;
  localparam logic [PC_W-1:0] SEG_NI  = 5'd23;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return Q_MAX;
    else if (v < -40'sd2147483648) return Q_MIN;
    else return v[Q_W-1:0];
  endfunction

  function automatic uop_t mk_uop(input opnd_t a, input opnd_t b, input acc_op_t c,
                                  input wb_t w, input logic l);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.acc   = c;
    u.wb    = w;
    u.last  = l;
    return u;
  endfunction

  // A product is registered in prod_r before the accumulator takes it into acc_r;
  // write-back then reads the registered acc_r.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] addr);
    uop_t u;
    case (addr)
      // z^2, z^3 - c and |f|^2
      5'd0:  u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_NONE, 1'b0);
      5'd1:  u = mk_uop(OP_ZI, OP_ZI, ACC_LD,   WB_NONE, 1'b0);
      5'd2:  u = mk_uop(OP_ZR, OP_ZI, ACC_SUB,  WB_NONE, 1'b0);
      5'd3:  u = mk_uop(OP_ZR, OP_ZI, ACC_LD,   WB_AR,   1'b0);
      5'd4:  u = mk_uop(OP_AR, OP_ZR, ACC_ADD,  WB_NONE, 1'b0);
      5'd5:  u = mk_uop(OP_ZR, OP_ZR, ACC_LD,   WB_AI,   1'b0);
      5'd6:  u = mk_uop(OP_AI, OP_ZI, ACC_NONE, WB_NONE, 1'b0);
      5'd7:  u = mk_uop(OP_AR, OP_ZI, ACC_SUB,  WB_NONE, 1'b0);
      5'd8:  u = mk_uop(OP_AI, OP_ZR, ACC_LD,   WB_FR,   1'b0);
      5'd9:  u = mk_uop(OP_FR, OP_FR, ACC_ADD,  WB_NONE, 1'b0);
      5'd10: u = mk_uop(OP_ZR, OP_ZR, ACC_LD,   WB_FI,   1'b0);
      5'd11: u = mk_uop(OP_FI, OP_FI, ACC_NONE, WB_NONE, 1'b0);
      5'd12: u = mk_uop(OP_ZR, OP_ZR, ACC_ADD,  WB_NONE, 1'b0);
      5'd13: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_MAG,  1'b1);
      // d = 3 z^2 and |d|^2
      5'd14: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_D,    1'b0);
      5'd15: u = mk_uop(OP_DR, OP_DR, ACC_NONE, WB_NONE, 1'b0);
      5'd16: u = mk_uop(OP_DI, OP_DI, ACC_LD,   WB_NONE, 1'b0);
      5'd17: u = mk_uop(OP_ZR, OP_ZR, ACC_ADD,  WB_NONE, 1'b0);
      5'd18: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_DEN,  1'b1);
      // real numerator fr*dr + fi*di
      5'd19: u = mk_uop(OP_FR, OP_DR, ACC_NONE, WB_NONE, 1'b0);
      5'd20: u = mk_uop(OP_FI, OP_DI, ACC_LD,   WB_NONE, 1'b0);
      5'd21: u = mk_uop(OP_ZR, OP_ZR, ACC_ADD,  WB_NONE, 1'b0);
      5'd22: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_NUM,  1'b1);
      // imaginary numerator fi*dr - fr*di
      5'd23: u = mk_uop(OP_FI, OP_DR, ACC_NONE, WB_NONE, 1'b0);
      5'd24: u = mk_uop(OP_FR, OP_DI, ACC_LD,   WB_NONE, 1'b0);
      5'd25: u = mk_uop(OP_ZR, OP_ZR, ACC_SUB,  WB_NONE, 1'b0);
      5'd26: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_NUM,  1'b1);
      default: u = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_NONE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

>>> src/nfp_div.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel: shared divider
// Restoring divider, one quotient bit per cycle, rounded and saturated Q4.28.
// ---------------------------------------------------------------------------
module nfp_div import nfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  neg,
  input  logic [63:0]           mag,
  input  logic [63:0]           den,
  output logic                  done,
  output logic signed [Q_W-1:0] quot
);

  div_state_t  state_r;
  logic [63:0] rem_r;
  logic [63:0] den_r;
  logic [32:0] bits_r;
  logic [32:0] quo_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic        ovf_r;

  logic        ovf;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;
  logic [33:0] rnd_sum;
  logic [32:0] rmag;

  // quotient of 16 or more saturates at once
  assign ovf   = {4'b0, mag} >= {den, 4'b0};
  assign trial = {rem_r, bits_r[32]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      case (state_r)
        DV_IDLE: begin
          if (start) begin
            state_r <= ovf ? DV_FIN : DV_RUN;
          end
        end
        DV_RUN: begin
          if (cnt_r == 6'd32) begin
            state_r <= DV_FIN;
          end
        end
        DV_FIN:  state_r <= DV_IDLE;
        default: state_r <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      rem_r  <= {4'b0, mag[63:4]};
      bits_r <= {mag[3:0], 29'b0};
      den_r  <= den;
      neg_r  <= neg;
      ovf_r  <= ovf;
      quo_r  <= '0;
      cnt_r  <= '0;
    end else if (state_r == DV_RUN) begin
      rem_r  <= ge ? diff[63:0] : trial[63:0];
      bits_r <= {bits_r[31:0], 1'b0};
      quo_r  <= {quo_r[31:0], ge};
      cnt_r  <= cnt_r + 6'd1;
    end
  end

  // round half away from zero on the magnitude, then apply sign and saturate
  assign rnd_sum = {1'b0, quo_r} + 34'd1;
  assign rmag    = rnd_sum[33:1];
  assign done    = (state_r == DV_FIN);

  always_comb begin
    if (neg_r) begin
      if (ovf_r || rmag >= 33'h0_8000_0000) quot = Q_MIN;
      else quot = -$signed({1'b0, rmag[30:0]});
    end else begin
      if (ovf_r || rmag > 33'h0_7FFF_FFFF) quot = Q_MAX;
      else quot = $signed({1'b0, rmag[30:0]});
    end
  end

endmodule

>>> src/nfp_dpath.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel: datapath
// Registers, shared multiplier, accumulator, divider and result register.
// ---------------------------------------------------------------------------
module nfp_dpath import nfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PIX_W-1:0]     in_pixel_x,
  input  logic [PIX_W-1:0]     in_pixel_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     out_step_count,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue
);

  logic signed [Q_W-1:0] c_real_r, c_imag_r;
  logic [CNT_W-1:0]      step_cap_r;
  logic [PIX_W-1:0]      px_r, py_r;
  logic signed [Q_W-1:0] zr_r, zi_r, ar_r, ai_r, fr_r, fi_r, dr_r, di_r, qr_r, qi_r;
  logic signed [63:0]    prod_r;
  logic signed [65:0]    acc_r;
  logic [63:0]           den_r, num_r;
  logic                  conv_r, den_zero_r;
  logic [CNT_W-1:0]      n_r;
  div_mode_t             div_mode_r;
  logic                  out_valid_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic [7:0]            out_red_r, out_green_r, out_blue_r;

  logic signed [Q_W-1:0] mul_a, mul_b;
  logic signed [63:0]    prod_c;
  logic signed [65:0]    rnd_t;
  logic signed [37:0]    rnd_sh;
  logic signed [Q_W-1:0] rnd_q, f_q, dr_q, di_q, zr_q, zi_q;
  logic signed [15:0]    sx, sy, mx, absx, absy;
  logic                  dv_neg;
  logic [63:0]           dv_mag, dv_den;
  logic                  dv_done;
  logic signed [Q_W-1:0] dv_quot;

  function automatic logic [7:0] shade(input logic [CNT_W-1:0] n, input logic [3:0] k);
    logic [11:0] p;
    logic [8:0]  s;
    p = 12'(n) * 12'(k);
    s = 9'(p[11:8]) + 9'(p[7:0]);
    if (s >= 9'd255) s = s - 9'd255;
    return 8'd255 - s[7:0];
  endfunction

  always_comb begin
    case (cmd.uop.a_sel)
      OP_ZR:   mul_a = zr_r;
      OP_ZI:   mul_a = zi_r;
      OP_AR:   mul_a = ar_r;
      OP_AI:   mul_a = ai_r;
      OP_FR:   mul_a = fr_r;
      OP_FI:   mul_a = fi_r;
      OP_DR:   mul_a = dr_r;
      OP_DI:   mul_a = di_r;
      default: mul_a = zr_r;
    endcase
    case (cmd.uop.b_sel)
      OP_ZR:   mul_b = zr_r;
      OP_ZI:   mul_b = zi_r;
      OP_AR:   mul_b = ar_r;
      OP_AI:   mul_b = ai_r;
      OP_FR:   mul_b = fr_r;
      OP_FI:   mul_b = fi_r;
      OP_DR:   mul_b = dr_r;
      OP_DI:   mul_b = di_r;
      default: mul_b = zr_r;
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // round half up to Q4.28 and saturate
  assign rnd_t  = acc_r + 66'sd134217728;
  assign rnd_sh = rnd_t[65:28];
  assign rnd_q  = sat_q(40'(rnd_sh));
  assign f_q    = sat_q(40'(rnd_q) - 40'((cmd.uop.wb == WB_FI) ? c_imag_r : c_real_r));
  assign dr_q   = sat_q(40'(ar_r) * 40'sd3);
  assign di_q   = sat_q(40'(ai_r) * 40'sd3);
  assign zr_q   = sat_q(40'(zr_r) - 40'(qr_r));
  assign zi_q   = sat_q(40'(zi_r) - 40'(qi_r));

  // divider operand selection
  assign sx   = $signed(16'({px_r, 1'b0})) - 16'(IMAGE_WIDTH);
  assign sy   = $signed(16'({py_r, 1'b0})) - 16'(IMAGE_HEIGHT);
  assign mx   = sx * 16'sd3;
  assign absx = mx[15] ? -mx : mx;
  assign absy = sy[15] ? -sy : sy;

  always_comb begin
    case (cmd.div_mode)
      DIV_MAPX: begin
        dv_neg = mx[15];
        dv_mag = 64'($unsigned(absx));
        dv_den = 64'(2 * IMAGE_WIDTH);
      end
      DIV_MAPY: begin
        dv_neg = sy[15];
        dv_mag = 64'($unsigned(absy));
        dv_den = 64'(IMAGE_HEIGHT);
      end
      default: begin
        dv_neg = num_r[63] & (|num_r[62:0]);
        dv_mag = dv_neg ? (~num_r + 64'd1) : num_r;
        dv_den = den_r;
      end
    endcase
  end

  nfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .neg   (dv_neg),
    .mag   (dv_mag),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r   <= C_REAL_RST;
      c_imag_r   <= C_IMAG_RST;
      step_cap_r <= STEP_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_C_REAL:   c_real_r   <= cfg_wdata;
        CFG_C_IMAG:   c_imag_r   <= cfg_wdata;
        CFG_STEP_CAP: step_cap_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    if (cmd.in_load) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (cmd.div_start) div_mode_r <= cmd.div_mode;
    case (cmd.uop.acc)
      ACC_LD:  acc_r <= 66'(prod_r);
      ACC_ADD: acc_r <= acc_r + 66'(prod_r);
      ACC_SUB: acc_r <= acc_r - 66'(prod_r);
      default: ;
    endcase
    case (cmd.uop.wb)
      WB_AR:  ar_r <= rnd_q;
      WB_AI:  ai_r <= rnd_q;
      WB_FR:  fr_r <= f_q;
      WB_FI:  fi_r <= f_q;
      WB_MAG: conv_r <= (acc_r[63:0] <= CONV_LIMIT);
      WB_D: begin
        dr_r <= dr_q;
        di_r <= di_q;
      end
      WB_DEN: begin
        den_r      <= acc_r[63:0];
        den_zero_r <= (acc_r[63:0] == 64'd0);
      end
      WB_NUM: num_r <= acc_r[63:0];
      WB_Z: begin
        zr_r <= zr_q;
        zi_r <= zi_q;
      end
      default: ;
    endcase
    if (dv_done) begin
      case (div_mode_r)
        DIV_MAPX: zr_r <= dv_quot;
        DIV_MAPY: zi_r <= dv_quot;
        DIV_QR:   qr_r <= dv_quot;
        DIV_QI:   qi_r <= dv_quot;
        default: ;
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (cmd.in_load) n_r <= '0;
    else if (cmd.n_max) n_r <= step_cap_r;
    else if (cmd.n_inc) n_r <= n_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cnt_r   <= n_r;
      out_red_r   <= shade(n_r, SHADE_K_RED);
      out_green_r <= shade(n_r, SHADE_K_GREEN);
      out_blue_r  <= shade(n_r, SHADE_K_BLUE);
    end
  end

  assign stat.div_done = dv_done;
  assign stat.conv     = conv_r;
  assign stat.den_zero = den_zero_r;
  assign stat.n_lim    = (n_r >= step_cap_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_step_count = out_cnt_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;

endmodule

>>> src/nfp_ctrl.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel: controller
// Sequences mapping, Newton steps and result handoff; runs the microprogram.
// ---------------------------------------------------------------------------
`include "newton_fractal_pixel_top_defines.svh"

module nfp_ctrl import nfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            uop_cur;
  logic            div_wait;

  function automatic logic [PC_W-1:0] seg_base(input ctrl_state_t s);
    case (s)
      ST_CUBE, ST_CUBE2: return SEG_CM;
      ST_DEN:            return SEG_DEN;
      ST_NR:             return SEG_NR;
      ST_NI:             return SEG_NI;
      default:           return SEG_CM;
    endcase
  endfunction

  assign uop_cur = uop_rom(pc_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MAPX;
      ST_MAPX:   state_nxt = ST_MAPX_W;
      ST_MAPX_W: if (stat.div_done) state_nxt = ST_MAPY;
      ST_MAPY:   state_nxt = ST_MAPY_W;
      ST_MAPY_W: if (stat.div_done) state_nxt = ST_CUBE;
      ST_CUBE:   if (uop_cur.last) state_nxt = ST_LIMIT;
      ST_LIMIT:  state_nxt = stat.n_lim ? ST_DONE : ST_DEN;
      ST_DEN:    if (uop_cur.last) state_nxt = ST_DZ;
      ST_DZ:     state_nxt = stat.den_zero ? ST_DONE : ST_NR;
      ST_NR:     if (uop_cur.last) state_nxt = ST_DIVR;
      ST_DIVR:   state_nxt = ST_DIVR_W;
      ST_DIVR_W: if (stat.div_done) state_nxt = ST_NI;
      ST_NI:     if (uop_cur.last) state_nxt = ST_DIVI;
      ST_DIVI:   state_nxt = ST_DIVI_W;
      ST_DIVI_W: if (stat.div_done) state_nxt = ST_ZUPD;
      ST_ZUPD:   state_nxt = ST_CUBE2;
      ST_CUBE2:  if (uop_cur.last) state_nxt = ST_CONV;
      ST_CONV:   state_nxt = stat.conv ? ST_DONE : ST_LIMIT;
      ST_DONE:   if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    pc_nxt = (state_nxt != state_r) ? seg_base(state_nxt) : pc_r + 1'b1;
  end

  always_comb begin
    cmd           = '0;
    cmd.uop       = mk_uop(OP_ZR, OP_ZR, ACC_NONE, WB_NONE, 1'b0);
    cmd.div_mode  = DIV_QR;
    case (state_r)
      ST_IDLE:  cmd.in_load = in_valid;
      ST_MAPX: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_MAPX;
      end
      ST_MAPY: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_MAPY;
      end
      ST_CUBE, ST_DEN, ST_NR, ST_NI, ST_CUBE2: cmd.uop = uop_cur;
      ST_DZ:    cmd.n_max = stat.den_zero;
      ST_DIVR: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_QR;
      end
      ST_DIVI: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_QI;
      end
      ST_ZUPD:  cmd.uop.wb = WB_Z;
      ST_CONV:  cmd.n_inc = !stat.conv;
      ST_DONE:  cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  // hold the input off in reset as well as while a pixel is in flight
  assign in_stall = (state_r != ST_IDLE) || !rst_n;

  assign div_wait = (state_r == ST_MAPX_W) || (state_r == ST_MAPY_W) ||
                    (state_r == ST_DIVR_W) || (state_r == ST_DIVI_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= SEG_CM;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  `NFP_ASSERT_IMPL(a_out_load_free, cmd.out_load, stat.out_free, "result register overwritten")
  `NFP_ASSERT_IMPL(a_div_done_wait, stat.div_done, div_wait, "divider done outside a wait")
  `NFP_ASSERT_NEXT(a_accept_maps, in_valid && !in_stall, state_r == ST_MAPX, "word not mapped")

endmodule

>>> src/newton_fractal_pixel_top.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel top level
// Newton iteration for z^3 - c on one pixel, Q4.28 fixed point, with color.
// ---------------------------------------------------------------------------
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+-----------------
//  in      | input     | in_pixel_x, in_pixel_y                 | in_valid/in_stall
//  out     | output    | out_step_count, out_red/green/blue     | out_valid/out_stall
//  cfg     | input     | cfg_index, cfg_wdata                   | cfg_we, no wait
//
//  One word at a time: after accept the pixel is mapped and z^3 - c formed,
//  then the Newton steps run; the shared restoring divider (33 quotient
//  bits plus a finish state, run twice per step) and the single 32x32
//  multiplier set the pace.
//  Synchronous active-low reset clears the controller, the divider and the
//  result valid, and loads c = 1.0, step limit = 50. No clearing pass.
//  A finished word waits in the result register; the next input word is taken
//  while it waits, and only the handoff of the following result holds on stall.
// ---------------------------------------------------------------------------
module newton_fractal_pixel_top import nfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_x,
  input  logic [PIX_W-1:0]     in_pixel_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     out_step_count,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata
);

  // command and status between controller and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: mapping, microprogram segments, divider waits, result handoff
  nfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, configuration registers and result register
  nfp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_count (out_step_count),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule

>>> verif/tb_newton_fractal_pixel_top.sv
// ---------------------------------------------------------------------------
// Newton fractal pixel testbench
// Drives pixel words through the valid/stall input channel with random gaps
// and stalls on the result side. A fixed-point Newton solver in the bench
// predicts the step count and shade of every pixel. Each result word is
// checked field by field, in order, against that prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_newton_fractal_pixel_top;
  import nfp_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [7:0] steps;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_shade_t;

  localparam longint QHI       = 64'sd2147483647;
  localparam longint QLO       = -64'sd2147483648;
  localparam u64_t   HALF_WRAP = 64'h8000_0000_0000_0000;
  localparam u64_t   FRAC_MASK = 64'h0000_0000_0FFF_FFFF;
  localparam u64_t   CONV_MAG  = 64'd720575940;
  // Cycles in which no word moves on either channel before the run is
  // declared hung.
  localparam int     HANG_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_x = '0;
  logic [PIX_W-1:0]     in_pixel_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CNT_W-1:0]     out_step_count;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_C_REAL;
  logic [Q_W-1:0]       cfg_wdata = '0;

  // Bench copy of the configuration registers.
  longint c_re;
  longint c_im;
  int     iter_cap;

  pixel_shade_t shade_q[$];
  int           errors = 0;
  bit           calm = 1'b0;
  int           idle_cycles = 0;

  newton_fractal_pixel_top uut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point Newton solver
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  // Exact (p1 + p2) / 2^28, ties toward plus infinity, then clamped.
  function automatic longint round_sum(longint p1, longint p2);
    u64_t   h1, h2, lo;
    longint hi;
    h1 = (u64_t'(p1) + HALF_WRAP) >> 28;
    h2 = (u64_t'(p2) + HALF_WRAP) >> 28;
    hi = (longint'(h1) - 64'sd34359738368) + (longint'(h2) - 64'sd34359738368);
    lo = (u64_t'(p1) & FRAC_MASK) + (u64_t'(p2) & FRAC_MASK);
    return clamp_q(hi + longint'((lo + 64'd134217728) >> 28));
  endfunction

  function automatic longint signed_mag(bit neg, u64_t mag);
    if (neg) return (mag >= 64'h8000_0000) ? QLO : -longint'(mag);
    return (mag > u64_t'(QHI)) ? QHI : longint'(mag);
  endfunction

  // Long division to 29 fraction bits, ties away from zero.
  function automatic longint quotient(u64_t num, u64_t den);
    bit   neg;
    u64_t m, q, r;
    neg = num > HALF_WRAP;
    m = neg ? (~num + 64'd1) : num;
    q = m / den;
    r = m % den;
    if (q >= 64'd16) return signed_mag(neg, 64'hFFFF_FFFF);
    for (int i = 0; i < 29; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return signed_mag(neg, (q + 64'd1) >> 1);
  endfunction

  function automatic longint map_coord(longint num, int shift, u64_t den);
    bit   neg;
    u64_t m;
    neg = num < 0;
    m = u64_t'(neg ? -num : num) << shift;
    return signed_mag(neg, (64'd2 * m + den) / (64'd2 * den));
  endfunction

  function automatic void cube_less_c(input longint zr, input longint zi,
                                      output longint ar, output longint ai,
                                      output longint fr, output longint fi);
    longint br, bi;
    ar = round_sum(zr * zr, -(zi * zi));
    ai = round_sum(zr * zi, zr * zi);
    br = round_sum(ar * zr, -(ai * zi));
    bi = round_sum(ar * zi, ai * zr);
    fr = clamp_q(br - c_re);
    fi = clamp_q(bi - c_im);
  endfunction

  function automatic pixel_shade_t solve_pixel(logic [PIX_W-1:0] px,
                                               logic [PIX_W-1:0] py);
    longint zr, zi, ar, ai, fr, fi, dr, di, qr, qi;
    u64_t den, mag;
    int n;
    pixel_shade_t s;
    n  = 0;
    zr = map_coord(3 * (2 * longint'(px) - IMAGE_WIDTH), 27, u64_t'(IMAGE_WIDTH));
    zi = map_coord(2 * longint'(py) - IMAGE_HEIGHT, 28, u64_t'(IMAGE_HEIGHT));
    cube_less_c(zr, zi, ar, ai, fr, fi);
    while (n < iter_cap) begin
      dr  = clamp_q(3 * ar);
      di  = clamp_q(3 * ai);
      den = u64_t'(dr * dr) + u64_t'(di * di);
      // degenerate derivative: give up at the step limit
      if (den == 0) begin
        n = iter_cap;
        break;
      end
      qr = quotient(u64_t'(fr * dr) + u64_t'(fi * di), den);
      qi = quotient(u64_t'(fi * dr) - u64_t'(fr * di), den);
      zr = clamp_q(zr - qr);
      zi = clamp_q(zi - qi);
      cube_less_c(zr, zi, ar, ai, fr, fi);
      mag = u64_t'(fr * fr) + u64_t'(fi * fi);
      if (mag <= CONV_MAG) break;
      n++;
    end
    s.steps = n[7:0];
    s.red   = 8'(255 - (n * 5) % 255);
    s.green = 8'(255 - (n * 7) % 255);
    s.blue  = 8'(255 - (n * 11) % 255);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall runs, checker, watchdog
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= calm ? 1'b0 : ($urandom_range(3) == 0);
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    pixel_shade_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $display("%0t: result word with none expected: steps %0d rgb %0d %0d %0d",
                 $time, out_step_count, out_red, out_green, out_blue);
        errors++;
      end else begin
        want = shade_q.pop_front();
        if (out_step_count !== want.steps) begin
          $display("%0t: step_count expected %0d actual %0d",
                   $time, want.steps, out_step_count);
          errors++;
        end
        if (out_red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, out_red);
          errors++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, out_green);
          errors++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_blue);
          errors++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("tb_newton_fractal_pixel_top: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // Offer one pixel word, hold it until taken, then predict its shade.
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (!(in_valid && !in_stall));
    shade_q.push_back(solve_pixel(px, py));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_C_REAL:   c_re = longint'($signed(val));
      CFG_C_IMAG:   c_im = longint'($signed(val));
      CFG_STEP_CAP: iter_cap = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [Q_W-1:0] cr, logic [Q_W-1:0] ci, logic [Q_W-1:0] mi);
    write_reg(CFG_C_REAL, cr);
    write_reg(CFG_C_IMAG, ci);
    write_reg(CFG_STEP_CAP, mi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: c = 1.0, 50 steps.
  task automatic test_reset_config();
    send_pixel(10'd600, 10'd300);
    send_pixel(10'd123, 10'd456);
    drain();
  endtask

  // Image center maps to z = 0, so 3z^2 is zero at once.
  task automatic test_zero_derivative();
    send_pixel(10'd400, 10'd300);
    drain();
  endtask

  // Corners, all-ones codes past the image edge.
  task automatic test_coord_extremes();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd799, 10'd599);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    drain();
  endtask

  // Limit of zero, one and the largest count.
  task automatic test_step_limit();
    write_reg(CFG_STEP_CAP, 32'd0);
    send_pixel(10'd700, 10'd100);
    send_pixel(10'd400, 10'd300);
    drain();
    write_reg(CFG_STEP_CAP, 32'd1);
    send_pixel(10'd700, 10'd100);
    send_pixel(10'd200, 10'd500);
    drain();
    write_reg(CFG_STEP_CAP, 32'd255);
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd650, 10'd420);
    drain();
  endtask

  // Constant at the ends of the Q4.28 range, then c = 0.
  task automatic test_c_extremes();
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd16);
    send_pixel(10'd100, 10'd100);
    send_pixel(10'd750, 10'd550);
    drain();
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd16);
    send_pixel(10'd300, 10'd50);
    send_pixel(10'd1023, 10'd1023);
    drain();
    set_config(32'h0000_0000, 32'h0000_0000, 32'd16);
    send_pixel(10'd500, 10'd200);
    drain();
  endtask

  // Random pixels over several random settings; one short run at the top limit.
  task automatic test_random_pixels();
    logic [Q_W-1:0] cr, ci;
    int             mi, count;
    for (int phase = 0; phase < 7; phase++) begin
      calm = (phase == 2);
      if (phase == 5) begin
        cr = $urandom;
        ci = $urandom;
      end else begin
        cr = 32'($signed($urandom_range(32'h2000_0000)) * ($urandom_range(1) ? 1 : -1));
        ci = 32'($signed($urandom_range(32'h2000_0000)) * ($urandom_range(1) ? 1 : -1));
      end
      mi    = (phase == 6) ? 255 : $urandom_range(40, 1);
      count = (phase == 6) ? 10 : 48;
      set_config(cr, ci, mi);
      repeat (count) begin
        if ($urandom_range(9) == 0)
          send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
        else
          send_pixel(10'($urandom_range(799)), 10'($urandom_range(599)));
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    c_re     = longint'($signed(C_REAL_RST));
    c_im     = longint'($signed(C_IMAG_RST));
    iter_cap = STEP_CAP_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_zero_derivative();
    test_coord_extremes();
    test_step_limit();
    test_c_extremes();
    test_random_pixels();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_newton_fractal_pixel_top: done, clean");
    else
      $display("tb_newton_fractal_pixel_top: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/nfp_pkg.sv
src/nfp_div.sv
src/nfp_dpath.sv
src/nfp_ctrl.sv
src/newton_fractal_pixel_top.sv
verif/tb_newton_fractal_pixel_top.sv
